### hdl/fwdf_pkg.sv
// Shared types and constants of the fixed-width decimal formatter.
`timescale 1ns / 1ps

package fwdf_pkg;

  localparam int MAX_DIGITS = 9;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 8;
  localparam int CHAR_W     = 6;
  localparam int DIGIT_W    = 4;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
  localparam int POS_W      = $clog2(MAX_DIGITS + 1);
  localparam int DIG_IDX_W  = $clog2(BCD_DIGITS);
  localparam int BIT_CNT_W  = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  typedef logic [BCD_W-1:0] fwdf_bcd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] digit_count;
  } fwdf_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } fwdf_out_t;

endpackage

### hdl/fwdf_dabble.sv
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
`timescale 1ns / 1ps

module fwdf_dabble import fwdf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [VALUE_W-1:0] value,
  output logic               done,
  output fwdf_bcd_t          bcd
);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dab_state_t;

  dab_state_t           state;
  logic [VALUE_W-1:0]   bin;
  logic [BIT_CNT_W-1:0] cnt;
  fwdf_bcd_t            adj;
  fwdf_bcd_t            bcd_next;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] > 4'd4) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
    bcd_next = {adj[BCD_W-2:0], bin[VALUE_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (go) begin
            bin   <= value;
            bcd   <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          bcd <= bcd_next;
          bin <= {bin[VALUE_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == BIT_CNT_W'(VALUE_W - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/fixed_width_decimal_formatter.sv
// Top level of the fixed-width decimal formatter: sequencer and character output.
//
// Input: an item (value, digit_count) is taken at a rising edge where start is
// high and busy is low. digit_count above 9 is treated as 9; a width of zero
// is taken but produces nothing and leaves the block idle.
// Work: a shift-and-add-3 converter turns the 32-bit value into ten BCD digits,
// one bit per cycle. Then one character is issued per cycle, most
// significant first, leading zeros shown as spaces, the units digit always a
// digit.
// Output: each character sits on result for exactly one cycle with strobe
// high; result.last marks the final character. The characters of one item
// come on consecutive cycles. The first strobe follows the end of the
// conversion; busy drops as the last character is registered. The receiver
// cannot stall: a strobed result is taken in its cycle.
// Reset: synchronous, active high; the block returns to idle with no strobe.
`timescale 1ns / 1ps

module fixed_width_decimal_formatter import fwdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  fwdf_in_t  item,
  output logic      strobe,
  output fwdf_out_t result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } fmt_state_t;

  fmt_state_t           state;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     width;
  logic                 seen;
  logic                 conv_go;
  logic                 conv_done;
  fwdf_bcd_t            bcd;
  logic [DIG_IDX_W-1:0] dig_idx;
  logic [DIGIT_W-1:0]   digit;
  logic                 show;

  assign busy = (state != S_IDLE);

  always_comb begin
    if (item.digit_count > COUNT_W'(MAX_DIGITS)) begin
      width = POS_W'(MAX_DIGITS);
    end else begin
      width = item.digit_count[POS_W-1:0];
    end
  end

  assign conv_go = start && !busy && (width != '0);
  assign dig_idx = DIG_IDX_W'(pos - 1'b1);
  assign digit   = bcd[dig_idx*DIGIT_W +: DIGIT_W];
  assign show    = seen || (digit != '0) || (pos == POS_W'(1));

  fwdf_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .go    (conv_go),
    .value (item.value),
    .done  (conv_done),
    .bcd   (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      seen   <= 1'b0;
      pos    <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (conv_go) begin
            pos   <= width;
            seen  <= 1'b0;
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe <= 1'b1;
          if (show) begin
            result.char_code <= CHAR_ZERO + CHAR_W'(digit);
            seen             <= 1'b1;
          end else begin
            result.char_code <= CHAR_SPACE;
          end
          result.last <= (pos == POS_W'(1));
          pos         <= pos - 1'b1;
          if (pos == POS_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("strobe continued after last character");

  a_chars_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("gap inside a character run");

  a_mid_run_emitting: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> state == S_EMIT)
    else $error("character run left emit state early");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> state == S_CONV)
    else $error("conversion finished outside conversion state");

endmodule

### tb/tb.sv
// Testbench of the fixed-width decimal formatter: digit predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

class char_scoreboard;
  fwdf_pkg::fwdf_out_t expected_chars[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  function void note_item(fwdf_pkg::fwdf_in_t it);
    int unsigned width;
    longint unsigned wide_value;
    longint unsigned divisor;
    int unsigned digit;
    bit seen;
    fwdf_pkg::fwdf_out_t ch;
    width = (it.digit_count > fwdf_pkg::MAX_DIGITS) ? fwdf_pkg::MAX_DIGITS : it.digit_count;
    wide_value = {32'd0, it.value};
    seen = 1'b0;
    for (int pos = width; pos > 0; pos--) begin
      divisor = 1;
      repeat (pos - 1) divisor = divisor * 10;
      digit = int'((wide_value / divisor) % 10);
      if (seen || digit != 0 || pos == 1) begin
        seen = 1'b1;
        ch.char_code = fwdf_pkg::CHAR_ZERO + 6'(digit);
      end else begin
        ch.char_code = fwdf_pkg::CHAR_SPACE;
      end
      ch.last = (pos == 1);
      expected_chars.push_back(ch);
    end
  endfunction

  function void check_char(fwdf_pkg::fwdf_out_t got);
    fwdf_pkg::fwdf_out_t want;
    if (expected_chars.size() == 0) begin
      $error("char_code: expected none, got %0d (last %0d)", got.char_code, got.last);
      mismatches++;
      return;
    end
    want = expected_chars.pop_front();
    if (got.char_code !== want.char_code) begin
      $error("char_code: expected %0d, got %0d", want.char_code, got.char_code);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
  endfunction
endclass

module tb;
  import fwdf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 119;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  fwdf_in_t  item = '0;
  logic      strobe;
  fwdf_out_t result;

  char_scoreboard scoreboard = new();
  int unsigned sender_idle_pct = 0;
  int unsigned cycle_count = 0;

  fixed_width_decimal_formatter dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) scoreboard.check_char(result);
  end

  task automatic send_number(input logic [VALUE_W-1:0] v, input logic [COUNT_W-1:0] n);
    fwdf_in_t it;
    it.value = v;
    it.digit_count = n;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      item <= {32'($urandom), 8'($urandom_range(0, 255))};
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    scoreboard.note_item(it);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (scoreboard.expected_chars.size() != 0) @(posedge clk);
  endtask

  function automatic fwdf_in_t random_number();
    fwdf_in_t it;
    int unsigned pick;
    int unsigned scale;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: it.value = $urandom;
      4, 5: it.value = $urandom_range(0, 999);
      6: begin
        it.value = $urandom_range(1, 9);
        scale = $urandom_range(0, 9);
        repeat (scale) it.value = it.value * 10;
      end
      7: it.value = $urandom_range(0, 9);
      8: it.value = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: it.value = $urandom_range(0, 99999);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 5) it.digit_count = '0;
    else if (pick < 85) it.digit_count = COUNT_W'($urandom_range(1, MAX_DIGITS));
    else if (pick < 93) it.digit_count = COUNT_W'($urandom_range(MAX_DIGITS + 1, 20));
    else it.digit_count = COUNT_W'($urandom_range(21, 255));
    return it;
  endfunction

  task automatic run_random_phase(input int unsigned idle_pct);
    fwdf_in_t it;
    sender_idle_pct = idle_pct;
    repeat (PHASE_ITEMS) begin
      it = random_number();
      send_number(it.value, it.digit_count);
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_number(32'd0, 8'd9);
    send_number(32'd0, 8'd1);
    send_number(32'd0, 8'd0);
    send_number(32'hFFFF_FFFF, 8'd9);
    send_number(32'hFFFF_FFFF, 8'd255);
    send_number(32'hFFFF_FFFF, 8'd10);
    send_number(32'hFFFF_FFFF, 8'd0);
    send_number(32'd123456789, 8'd9);
    send_number(32'd123456789, 8'd4);
    send_number(32'd1000000000, 8'd9);
    send_number(32'd999999999, 8'd9);
    send_number(32'd999999999, 8'd128);
    send_number(32'd100, 8'd1);
    send_number(32'd100, 8'd5);
    send_number(32'd7, 8'd3);
    send_number(32'd10, 8'd2);
    send_number(32'd1, 8'd9);
    send_number(32'd9, 8'd1);
    send_number(32'd40500, 8'd7);
    send_number(32'h8000_0000, 8'd8);
    send_number(32'h5555_5555, 8'h55);
    send_number(32'hAAAA_AAAA, 8'hAA);
    wait_drained();

    run_random_phase(34);
    run_random_phase(73);
    run_random_phase(0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
